### rtl/famr_pkg.sv
// Shared types and constants for the fraction arithmetic unit.
`default_nettype none
package famr_pkg;
    localparam int NUM_WIDTH_DEF = 16;
    localparam int OP_W    = 2;
    localparam int IN_W    = 16;
    localparam int RNUM_W  = 49;
    localparam int RDEN_W  = 32;

    typedef enum logic [OP_W-1:0] {
        OP_ADD = 2'd0,
        OP_MUL = 2'd1,
        OP_RED = 2'd2,
        OP_NOP = 2'd3
    } op_t;

    typedef struct packed {
        logic load;
        logic gcd_start;
        logic div_start;
        logic mul_start;
        logic [1:0] step;
    } famr_cmd_t;

    typedef struct packed {
        logic gcd_done;
        logic div_done;
        logic mul_done;
    } famr_sts_t;
endpackage
`default_nettype wire

### rtl/famr_if.sv
// Valid/ready channel carrying a payload of given type.
`default_nettype none
interface famr_if #(parameter type T = logic) (input wire logic clk);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

### rtl/famr_ctrl.sv
// Sequencer for the fraction unit: issues datapath steps per operation.
`default_nettype none
module famr_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire famr_pkg::op_t      op,
    input  wire logic               a_num_zero,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output famr_pkg::famr_cmd_t     cmd,
    input  wire famr_pkg::famr_sts_t sts
);
    import famr_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_GCD  = 7'b0000010,
        S_DIV1 = 7'b0000100,
        S_DIV2 = 7'b0001000,
        S_MUL1 = 7'b0010000,
        S_MUL2 = 7'b0100000,
        S_OUT  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    op_t    op_reg, op_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    op_next  = op;
                    if (op == OP_ADD || (op == OP_RED && !a_num_zero))
                    begin
                        cmd.gcd_start = 1'b1;
                        state_next    = S_GCD;
                    end
                    else if (op == OP_MUL)
                    begin
                        cmd.mul_start = 1'b1;
                        cmd.step      = 2'd0;
                        state_next    = S_MUL1;
                    end
                    else
                    begin
                        state_next = S_OUT;
                    end
                end
            end
            S_GCD:
            begin
                if (sts.gcd_done)
                begin
                    cmd.div_start = 1'b1;
                    cmd.step      = 2'd0;
                    state_next    = S_DIV1;
                end
            end
            S_DIV1:
            begin
                cmd.step = 2'd0;
                if (sts.div_done)
                begin
                    cmd.div_start = 1'b1;
                    cmd.step      = 2'd1;
                    state_next    = S_DIV2;
                end
            end
            S_DIV2:
            begin
                cmd.step = 2'd1;
                if (sts.div_done)
                begin
                    if (op_reg == OP_ADD)
                    begin
                        // lcm = (ad/g)*bd, then numerator terms
                        cmd.mul_start = 1'b1;
                        cmd.step      = 2'd1;
                        state_next    = S_MUL1;
                    end
                    else
                    begin
                        state_next = S_OUT;
                    end
                end
            end
            S_MUL1:
            begin
                if (sts.mul_done)
                begin
                    if (op_reg == OP_ADD)
                    begin
                        cmd.mul_start = 1'b1;
                        cmd.step      = 2'd2;
                        state_next    = S_MUL2;
                    end
                    else
                    begin
                        state_next = S_OUT;
                    end
                end
            end
            S_MUL2:
            begin
                if (sts.mul_done)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            op_reg    <= OP_NOP;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
        end
    end
endmodule
`default_nettype wire

### rtl/famr_dp.sv
// Datapath: operand registers, Euclid GCD, restoring divider, multiplier.
`default_nettype none
module famr_dp #(
    parameter int NUM_WIDTH = famr_pkg::NUM_WIDTH_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire famr_pkg::op_t                op,
    input  wire logic [famr_pkg::IN_W-1:0]    a_num,
    input  wire logic [famr_pkg::IN_W-1:0]    a_den,
    input  wire logic [famr_pkg::IN_W-1:0]    b_num,
    input  wire logic [famr_pkg::IN_W-1:0]    b_den,
    output logic                              a_num_zero,
    input  wire famr_pkg::famr_cmd_t          cmd,
    output famr_pkg::famr_sts_t               sts,
    output logic [famr_pkg::RNUM_W-1:0]       res_num,
    output logic [famr_pkg::RDEN_W-1:0]       res_den
);
    import famr_pkg::*;

    localparam int W   = (NUM_WIDTH < IN_W) ? NUM_WIDTH : IN_W;
    localparam int CW  = $clog2(W + 1);
    localparam int PW  = 2 * W;

    logic [W-1:0] an, ad, bn, bd;
    logic [W-1:0] an_reg, ad_reg, bn_reg, bd_reg;
    logic [W-1:0] gx_reg, gy_reg;
    logic         gcd_busy_reg;
    // divider
    logic [W-1:0] q_reg, rem_reg, dvd_reg, dvs_reg;
    logic [CW-1:0] dcnt_reg;
    logic         div_busy_reg;
    logic         div_fin_reg;
    logic [W-1:0] q1_reg;
    logic [W:0]   trial;
    // multiplier: one register stage, 2 steps per item max
    logic         mul_busy_reg;
    logic [PW-1:0] prod_reg;
    logic [PW-1:0] p1_reg;
    logic [1:0]   mstep_reg;
    logic [RNUM_W-1:0] rnum_reg;
    logic [RDEN_W-1:0] rden_reg;
    op_t          op_reg;
    logic [W-1:0] gr;
    logic [W-1:0] ma, mb;
    logic [PW:0]  sum;

    assign an = a_num[W-1:0];
    assign ad = (a_den[W-1:0] == '0) ? W'(1) : a_den[W-1:0];
    assign bn = b_num[W-1:0];
    assign bd = (b_den[W-1:0] == '0) ? W'(1) : b_den[W-1:0];
    assign a_num_zero = (an == '0);

    // subtraction form of Euclid: larger minus smaller each cycle until equal
    assign gr = (gx_reg >= gy_reg) ? gx_reg - gy_reg : gy_reg - gx_reg;

    assign trial = {rem_reg, dvd_reg[W-1]} - {1'b0, dvs_reg};

    // q1 = first quotient (ad/g or an/g), q = second (bd/g or ad/g)
    always_comb
    begin
        ma = '0;
        mb = '0;
        case (cmd.step)
            2'd0:
            begin
                ma = an;      // operands still on the input at load
                mb = bn;
            end
            2'd1:
            begin
                ma = q1_reg;  // ad/g = lcm/bd
                mb = bn_reg;
            end
            2'd2:
            begin
                ma = q_reg;   // bd/g = lcm/ad
                mb = an_reg;
            end
            default:
            begin
                ma = '0;
                mb = '0;
            end
        endcase
    end

    assign sum = {1'b0, prod_reg} + {1'b0, p1_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gcd_busy_reg <= 1'b0;
            div_busy_reg <= 1'b0;
            div_fin_reg  <= 1'b0;
            mul_busy_reg <= 1'b0;
            dcnt_reg     <= '0;
            mstep_reg    <= '0;
        end
        else
        begin
            if (cmd.gcd_start)
            begin
                gcd_busy_reg <= 1'b1;
            end
            else if (gcd_busy_reg && (gx_reg == gy_reg))
            begin
                gcd_busy_reg <= 1'b0;
            end
            // done flag rises in the cycle after the last step, once q_reg holds the quotient
            div_fin_reg <= div_busy_reg && (dcnt_reg == CW'(1));
            if (cmd.div_start)
            begin
                div_busy_reg <= 1'b1;
                dcnt_reg     <= CW'(W);
            end
            else if (div_busy_reg)
            begin
                dcnt_reg <= dcnt_reg - 1'b1;
                if (dcnt_reg == CW'(1))
                begin
                    div_busy_reg <= 1'b0;
                end
            end
            if (cmd.mul_start)
            begin
                mul_busy_reg <= 1'b1;
                mstep_reg    <= cmd.step;
            end
            else
            begin
                mul_busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            an_reg   <= an;
            ad_reg   <= ad;
            bn_reg   <= bn;
            bd_reg   <= bd;
            op_reg   <= op;
            rnum_reg <= '0;
            rden_reg <= RDEN_W'(1);
            if (op == OP_ADD)
            begin
                gx_reg <= ad;
                gy_reg <= bd;
            end
            else
            begin
                gx_reg <= an;
                gy_reg <= ad;
            end
        end
        else if (gcd_busy_reg && (gx_reg != gy_reg))
        begin
            if (gx_reg > gy_reg)
            begin
                gx_reg <= gr;
            end
            else
            begin
                gy_reg <= gr;
            end
        end
        if (cmd.div_start)
        begin
            rem_reg <= '0;
            dvs_reg <= gx_reg;
            if (cmd.step == 2'd0)
            begin
                dvd_reg <= (op_reg == OP_ADD) ? ad_reg : an_reg;
            end
            else
            begin
                q1_reg  <= q_reg;
                dvd_reg <= (op_reg == OP_ADD) ? bd_reg : ad_reg;
            end
        end
        else if (div_busy_reg)
        begin
            if (!trial[W])
            begin
                rem_reg <= trial[W-1:0];
            end
            else
            begin
                rem_reg <= {rem_reg[W-2:0], dvd_reg[W-1]};
            end
            dvd_reg <= {dvd_reg[W-2:0], !trial[W]};
            if (dcnt_reg == CW'(1))
            begin
                q_reg <= {dvd_reg[W-2:0], !trial[W]};
            end
        end
        if (cmd.mul_start)
        begin
            prod_reg <= PW'(ma) * PW'(mb);
            if (cmd.step == 2'd2)
            begin
                p1_reg <= prod_reg;
            end
        end
        if (mul_busy_reg)
        begin
            case (mstep_reg)
                2'd0:
                begin
                    rnum_reg <= RNUM_W'(prod_reg);
                    rden_reg <= RDEN_W'(PW'(ad_reg) * PW'(bd_reg));
                end
                2'd1:
                begin
                    rden_reg <= RDEN_W'(PW'(q1_reg) * PW'(bd_reg));
                end
                2'd2:
                begin
                    rnum_reg <= RNUM_W'(sum);
                end
                default:
                begin
                    rnum_reg <= rnum_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        res_num = rnum_reg;
        res_den = rden_reg;
        if (op_reg == OP_RED && !(an_reg == '0))
        begin
            res_num = RNUM_W'(q1_reg);
            res_den = RDEN_W'(q_reg);
        end
    end

    assign sts.gcd_done = gcd_busy_reg && (gx_reg == gy_reg);
    assign sts.div_done = div_fin_reg;
    assign sts.mul_done = mul_busy_reg;
endmodule
`default_nettype wire

### rtl/fraction_add_mul_reduce_top.sv
// Sequence: multiply runs one multiplier step; zero-numerator reduce and unused selector go
// straight to output; reduce runs the GCD loop and two divisions, and add two multiplies after
// them; the GCD loop takes up to about 2^W subtraction steps in the worst case.
// Throughput: one request at a time; a new request is taken the cycle after the result leaves.
// The subtraction GCD loop and the two bit-serial divisions set the rate.
// Reset: rst_n asynchronous, active low, returns the sequencer to idle.
`default_nettype none
module fraction_add_mul_reduce_top #(
    parameter int NUM_WIDTH = famr_pkg::NUM_WIDTH_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    famr_if.sink      in_ch,
    famr_if.source    out_ch
);
    import famr_pkg::*;

    famr_cmd_t cmd;
    famr_sts_t sts;
    logic      a_num_zero;

    famr_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_ch.valid),
        .in_ready   (in_ch.ready),
        .op         (op_t'(in_ch.data.operation)),
        .a_num_zero (a_num_zero),
        .out_valid  (out_ch.valid),
        .out_ready  (out_ch.ready),
        .cmd        (cmd),
        .sts        (sts)
    );

    famr_dp #(.NUM_WIDTH(NUM_WIDTH)) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .op         (op_t'(in_ch.data.operation)),
        .a_num      (in_ch.data.a_num),
        .a_den      (in_ch.data.a_den),
        .b_num      (in_ch.data.b_num),
        .b_den      (in_ch.data.b_den),
        .a_num_zero (a_num_zero),
        .cmd        (cmd),
        .sts        (sts),
        .res_num    (out_ch.data.res_num),
        .res_den    (out_ch.data.res_den)
    );

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ch.ready && out_ch.valid))
        else $error("input taken while result pending");
    a_load_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> in_ch.ready)
        else $error("load outside idle");
    a_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> (out_ch.data.res_den != '0))
        else $error("zero denominator");
endmodule
`default_nettype wire
